### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CBMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("controller assertion failed");

// Same check with a caller supplied message string.
`define CBMC_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

### src/cbmc_pkg.sv
// ----------------------------------------------------------------------------
// cbmc_pkg
// Types and constants of the camera button and shutter mode controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbmc_pkg;

    // Menu codes
    localparam logic [3:0] MENU_AUTO   = 4'd0;
    localparam logic [3:0] MENU_BULB   = 4'd1;
    localparam logic [3:0] MENU_TIME   = 4'd2;
    localparam logic [3:0] MENU_MANUAL = 4'd3;
    localparam logic [3:0] MENU_TIMER  = 4'd10;

    // Shutter mode codes
    localparam logic [1:0] SHUT_FLASH  = 2'd0;
    localparam logic [1:0] SHUT_NORMAL = 2'd1;
    localparam logic [1:0] SHUT_BULB   = 2'd2;
    localparam logic [1:0] SHUT_TIME   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_POLL_GATE    = 3'd0;
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] CFG_RELEASE_HOLD = 3'd2;
    localparam logic [2:0] CFG_SPEED_COUNT  = 3'd3;
    localparam logic [2:0] CFG_FLASH_CAP    = 3'd4;

    // Upper bound on manual speed steps
    localparam logic [5:0] MAX_SPEEDS = 6'd32;

    // Speed index used for bulb, time and unknown menus
    localparam logic [4:0] SPEED_DEFAULT = 5'd1;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        key_down_level;
        logic        key_up_level;
        logic        key_push_level;
        logic        half_press_pin;
        logic        full_press_pin;
        logic        flash_present;
        logic [4:0]  metered_speed;
    } t_poll;

    typedef struct packed {
        logic [3:0] menu_mode;
        logic [4:0] manual_speed_index;
        logic [1:0] timer_index;
        logic       focused;
        logic [1:0] shutter_mode;
        logic [4:0] shot_speed;
        logic       expose;
    } t_result;

    typedef struct packed {
        logic [15:0] poll_gate_ms;
        logic [15:0] long_press_ms;
        logic [7:0]  release_hold_count;
        logic [5:0]  speed_count;
        logic [4:0]  flash_speed_cap;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  menu;
        logic [4:0]  manual_speed;
        logic [1:0]  timer_idx;
        logic        focused;
        logic [1:0]  mode;
        logic [4:0]  speed;
        logic [2:0]  prev_keys;
        logic [31:0] last_scan_time;
        logic [31:0] push_start_time;
        logic [7:0]  half_hold;
        logic [7:0]  full_hold;
        logic        full_prev;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        poll_gate_ms:       16'd100,
        long_press_ms:      16'd1000,
        release_hold_count: 8'd3,
        speed_count:        6'd20,
        flash_speed_cap:    5'd11
    };

    localparam t_state STATE_RESET = '{
        menu:            MENU_AUTO,
        manual_speed:    5'd0,
        timer_idx:       2'd0,
        focused:         1'b0,
        mode:            SHUT_NORMAL,
        speed:           SPEED_DEFAULT,
        prev_keys:       3'b111,
        last_scan_time:  32'd0,
        push_start_time: 32'd0,
        half_hold:       8'd0,
        full_hold:       8'd0,
        full_prev:       1'b0
    };

endpackage

`default_nettype wire

### src/cbmc_if.sv
// ----------------------------------------------------------------------------
// cbmc channel interfaces
// Valid/ready channels for polls, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbmc_poll_if;
    logic            valid;
    logic            ready;
    cbmc_pkg::t_poll data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbmc_result_if;
    logic              valid;
    logic              ready;
    cbmc_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/cbmc_step.sv
// ----------------------------------------------------------------------------
// cbmc_step
// Next-state logic for one poll: key scan, hold counters, focus, expose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbmc_step (
    input  cbmc_pkg::t_state i_state,
    input  cbmc_pkg::t_cfg   i_cfg,
    input  cbmc_pkg::t_poll  i_poll,
    output cbmc_pkg::t_state o_state,
    output logic             o_expose
);

    logic [31:0] elapsed;
    logic [31:0] push_len;
    logic        scan;
    logic [5:0]  spd_cnt;
    logic [5:0]  spd_lim;
    logic [5:0]  spd_inc;
    logic [3:0]  menu_k;
    logic [4:0]  ms_k;
    logic [1:0]  ti_k;
    logic [31:0] push_k;
    logic [7:0]  half_n;
    logic [7:0]  full_n;
    logic        half_on;
    logic        full_on;
    logic        focus_a;
    logic        foc_a;
    logic        expose;
    logic        focus_b;
    logic [1:0]  f_mode;
    logic [4:0]  f_speed;

    assign elapsed  = i_poll.time_ms - i_state.last_scan_time;
    assign push_len = i_poll.time_ms - i_state.push_start_time;
    assign scan     = elapsed >= {16'd0, i_cfg.poll_gate_ms};
    assign spd_cnt  = (i_cfg.speed_count == 6'd0) ? 6'd1 : i_cfg.speed_count;
    assign spd_lim  = (spd_cnt > cbmc_pkg::MAX_SPEEDS) ? cbmc_pkg::MAX_SPEEDS : spd_cnt;

    // key scan
    always_comb begin
        menu_k  = i_state.menu;
        ms_k    = i_state.manual_speed;
        ti_k    = i_state.timer_idx;
        push_k  = i_state.push_start_time;
        spd_inc = 6'd0;
        if (scan) begin
            if (i_state.prev_keys[2] && !i_poll.key_down_level
                    && i_state.menu == cbmc_pkg::MENU_MANUAL) begin
                ms_k = (i_state.manual_speed == 5'd0) ? 5'(spd_lim - 6'd1)
                                                      : i_state.manual_speed - 5'd1;
            end
            spd_inc = {1'b0, ms_k} + 6'd1;
            if (i_state.prev_keys[1] && !i_poll.key_up_level) begin
                if (i_state.menu == cbmc_pkg::MENU_MANUAL) begin
                    ms_k = (spd_inc >= spd_lim) ? 5'd0 : spd_inc[4:0];
                end else if (i_state.menu == cbmc_pkg::MENU_TIMER) begin
                    ti_k = i_state.timer_idx + 2'd1;
                end
            end
            if (i_state.prev_keys[0] && !i_poll.key_push_level) begin
                push_k = i_poll.time_ms;
            end
            if (!i_state.prev_keys[0] && i_poll.key_push_level) begin
                if (push_len > {16'd0, i_cfg.long_press_ms}) begin
                    menu_k = (i_state.menu < cbmc_pkg::MENU_TIMER) ? cbmc_pkg::MENU_TIMER
                                                                  : cbmc_pkg::MENU_AUTO;
                end else begin
                    menu_k = {2'b00, i_state.menu[1:0] + 2'd1};
                end
            end
        end
    end

    // release-hold counters
    assign half_n  = i_poll.half_press_pin ? i_cfg.release_hold_count
                   : ((i_state.half_hold != 8'd0) ? i_state.half_hold - 8'd1 : 8'd0);
    assign full_n  = i_poll.full_press_pin ? i_cfg.release_hold_count
                   : ((i_state.full_hold != 8'd0) ? i_state.full_hold - 8'd1 : 8'd0);
    assign half_on = half_n != 8'd0;
    assign full_on = full_n != 8'd0;

    // focus and expose
    assign focus_a = half_on && !i_state.focused && menu_k != cbmc_pkg::MENU_TIMER;
    assign foc_a   = half_on && (i_state.focused || focus_a);
    assign expose  = full_on && !i_state.full_prev && menu_k != cbmc_pkg::MENU_TIMER;
    assign focus_b = expose && !foc_a;

    // mode and speed picked at focus
    always_comb begin
        f_mode  = cbmc_pkg::SHUT_NORMAL;
        f_speed = cbmc_pkg::SPEED_DEFAULT;
        if (i_poll.flash_present) begin
            f_mode  = cbmc_pkg::SHUT_FLASH;
            f_speed = (menu_k == cbmc_pkg::MENU_MANUAL && ms_k <= i_cfg.flash_speed_cap)
                    ? ms_k : i_cfg.flash_speed_cap;
        end else begin
            unique case (menu_k)
                cbmc_pkg::MENU_AUTO: begin
                    f_speed = i_poll.metered_speed;
                end
                cbmc_pkg::MENU_BULB: begin
                    f_mode = cbmc_pkg::SHUT_BULB;
                end
                cbmc_pkg::MENU_TIME: begin
                    f_mode = cbmc_pkg::SHUT_TIME;
                end
                cbmc_pkg::MENU_MANUAL: begin
                    f_speed = ms_k;
                end
                default: begin
                    f_mode  = cbmc_pkg::SHUT_NORMAL;
                end
            endcase
        end
    end

    always_comb begin
        o_state                 = i_state;
        o_state.menu            = menu_k;
        o_state.manual_speed    = ms_k;
        o_state.timer_idx       = ti_k;
        o_state.push_start_time = push_k;
        if (scan) begin
            o_state.prev_keys      = {i_poll.key_down_level, i_poll.key_up_level,
                                      i_poll.key_push_level};
            o_state.last_scan_time = i_poll.time_ms;
        end
        o_state.half_hold = half_n;
        o_state.full_hold = full_n;
        o_state.full_prev = full_on;
        o_state.focused   = foc_a || focus_b;
        if (focus_a || focus_b) begin
            o_state.mode  = f_mode;
            o_state.speed = f_speed;
        end
    end

    assign o_expose = expose;

endmodule

`default_nettype wire

### src/cbmc_out_buf.sv
// ----------------------------------------------------------------------------
// cbmc_out_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cbmc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cbmc_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output cbmc_pkg::t_result o_data,
    input  logic              i_ready
);

    logic              r_main_valid;
    logic              r_skid_valid;
    cbmc_pkg::t_result r_main;
    cbmc_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    `CBMC_ASSERT_MSG(a_skid_behind_main, i_clk, i_rst_n, r_skid_valid |-> r_main_valid, "skid full with empty output")
    `CBMC_ASSERT_MSG(a_skid_held, i_clk, i_rst_n, (r_skid_valid && !pop) |=> (r_skid_valid && $stable(r_skid)), "skid entry lost")

endmodule

`default_nettype wire

### src/camera_button_mode_controller.sv
// ----------------------------------------------------------------------------
// camera_button_mode_controller
// Key scan, menu, shutter hold and focus/expose control, one result per poll.
// ----------------------------------------------------------------------------
// Usage:
//   i_poll   : one poll per transfer (timestamp, key levels, shutter pins,
//              flash level, metered speed).
//   o_result : one result per poll, showing menu, manual speed, timer index,
//              focus, shutter mode and speed, and a one-poll expose pulse.
//   i_cfg    : register writes (index 0..4), always ready; write only while
//              no poll is in flight.
//   The result of a poll is registered in the output register or skid entry.
//   Throughput: one poll per cycle while i_poll.ready is high; the whole poll
//   is resolved by the next-state logic in the cycle it is taken.
//   Stall: an output register plus a skid entry hold up to two results;
//   i_poll.ready drops only while both are occupied.
//   Reset: synchronous, active low; registers return to their defaults
//   (gate 100 ms, long press 1000 ms, hold 3, 20 speeds, flash cap 11),
//   menu auto, normal mode at speed 1, all keys released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module camera_button_mode_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cbmc_poll_if.sink            i_poll,
    cbmc_result_if.source        o_result,
    cbmc_cfg_if.sink             i_cfg
);

    cbmc_pkg::t_cfg    r_cfg;
    cbmc_pkg::t_state  r_state;
    cbmc_pkg::t_state  n_state;
    cbmc_pkg::t_result n_result;
    logic              n_expose;
    logic              in_ready;
    logic              in_xfer;

    assign i_cfg.ready  = 1'b1;
    assign i_poll.ready = in_ready;
    assign in_xfer      = i_poll.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cbmc_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cbmc_pkg::CFG_POLL_GATE:    r_cfg.poll_gate_ms       <= i_cfg.data;
                cbmc_pkg::CFG_LONG_PRESS:   r_cfg.long_press_ms      <= i_cfg.data;
                cbmc_pkg::CFG_RELEASE_HOLD: r_cfg.release_hold_count <= i_cfg.data[7:0];
                cbmc_pkg::CFG_SPEED_COUNT:  r_cfg.speed_count        <= i_cfg.data[5:0];
                cbmc_pkg::CFG_FLASH_CAP:    r_cfg.flash_speed_cap    <= i_cfg.data[4:0];
                default: begin
                end
            endcase
        end
    end

    cbmc_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_poll   (i_poll.data),
        .o_state  (n_state),
        .o_expose (n_expose)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbmc_pkg::STATE_RESET;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    assign n_result = '{
        menu_mode:          n_state.menu,
        manual_speed_index: n_state.manual_speed,
        timer_index:        n_state.timer_idx,
        focused:            n_state.focused,
        shutter_mode:       n_state.mode,
        shot_speed:         n_state.speed,
        expose:             n_expose
    };

    cbmc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (n_result),
        .o_ready (in_ready),
        .o_valid (o_result.valid),
        .o_data  (o_result.data),
        .i_ready (o_result.ready)
    );

    `CBMC_ASSERT_MSG(a_expose_focused, i_clk, i_rst_n, (o_result.valid && o_result.data.expose) |-> o_result.data.focused, "expose without focus")
    `CBMC_ASSERT_MSG(a_menu_code, i_clk, i_rst_n, (r_state.menu < 4'd4) || (r_state.menu == cbmc_pkg::MENU_TIMER), "menu out of set")
    `CBMC_ASSERT_MSG(a_state_idle, i_clk, i_rst_n, !in_xfer |=> $stable(r_state), "state moved without a poll")

endmodule

`default_nettype wire

### test/camera_button_mode_controller_checker.sv
// ----------------------------------------------------------------------------
// camera_button_mode_controller_checker
// Watches the poll, result and register write channels, keeps its own copy of
// the controller state and settings, predicts one result per poll transfer and
// compares every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_button_mode_controller_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cbmc_poll_if   i_poll,
    cbmc_result_if i_result,
    cbmc_cfg_if    i_cfg,
    output int     o_fail_count,
    output int     o_pending
);

    import cbmc_pkg::*;

    t_cfg    settings;
    t_state  ctl;
    t_result predicted_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void latch_focus(logic flash, logic [4:0] metered);
        ctl.focused = 1'b1;
        if (flash) begin
            ctl.mode = SHUT_FLASH;
            if (ctl.menu == MENU_MANUAL && ctl.manual_speed <= settings.flash_speed_cap)
                ctl.speed = ctl.manual_speed;
            else
                ctl.speed = settings.flash_speed_cap;
        end else begin
            case (ctl.menu)
                MENU_AUTO: begin
                    ctl.mode  = SHUT_NORMAL;
                    ctl.speed = metered;
                end
                MENU_BULB: begin
                    ctl.mode  = SHUT_BULB;
                    ctl.speed = SPEED_DEFAULT;
                end
                MENU_TIME: begin
                    ctl.mode  = SHUT_TIME;
                    ctl.speed = SPEED_DEFAULT;
                end
                MENU_MANUAL: begin
                    ctl.mode  = SHUT_NORMAL;
                    ctl.speed = ctl.manual_speed;
                end
                default: begin
                    ctl.mode  = SHUT_NORMAL;
                    ctl.speed = SPEED_DEFAULT;
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] next_hold(logic [7:0] cnt, logic pin);
        if (pin)
            return settings.release_hold_count;
        return (cnt != 8'd0) ? cnt - 8'd1 : 8'd0;
    endfunction

    function automatic t_result resolve_poll(t_poll p);
        logic [2:0] keys;
        logic [5:0] steps;
        logic [5:0] last_step;
        logic       half_on;
        logic       full_on;
        logic       fire;
        t_result    r;
        keys = {p.key_down_level, p.key_up_level, p.key_push_level};
        fire = 1'b0;
        if (p.time_ms - ctl.last_scan_time >= {16'd0, settings.poll_gate_ms}) begin
            steps = (settings.speed_count == 6'd0) ? 6'd1 : settings.speed_count;
            if (steps > MAX_SPEEDS)
                steps = MAX_SPEEDS;
            last_step = steps - 6'd1;
            if (ctl.prev_keys[2] && !keys[2] && ctl.menu == MENU_MANUAL)
                ctl.manual_speed = (ctl.manual_speed == 5'd0) ? last_step[4:0]
                                                              : ctl.manual_speed - 5'd1;
            if (ctl.prev_keys[1] && !keys[1]) begin
                if (ctl.menu == MENU_MANUAL)
                    ctl.manual_speed = ({1'b0, ctl.manual_speed} + 6'd1 >= steps)
                                       ? 5'd0 : ctl.manual_speed + 5'd1;
                else if (ctl.menu == MENU_TIMER)
                    ctl.timer_idx = ctl.timer_idx + 2'd1;
            end
            if (ctl.prev_keys[0] && !keys[0])
                ctl.push_start_time = p.time_ms;
            if (!ctl.prev_keys[0] && keys[0]) begin
                if (p.time_ms - ctl.push_start_time > {16'd0, settings.long_press_ms})
                    ctl.menu = (ctl.menu < MENU_TIMER) ? MENU_TIMER : MENU_AUTO;
                else
                    ctl.menu = {2'b00, ctl.menu[1:0] + 2'd1};
            end
            ctl.prev_keys      = keys;
            ctl.last_scan_time = p.time_ms;
        end
        ctl.half_hold = next_hold(ctl.half_hold, p.half_press_pin);
        ctl.full_hold = next_hold(ctl.full_hold, p.full_press_pin);
        half_on = (ctl.half_hold != 8'd0);
        full_on = (ctl.full_hold != 8'd0);
        if (half_on && !ctl.focused && ctl.menu != MENU_TIMER)
            latch_focus(p.flash_present, p.metered_speed);
        if (!half_on)
            ctl.focused = 1'b0;
        if (full_on && !ctl.full_prev && ctl.menu != MENU_TIMER) begin
            if (!ctl.focused)
                latch_focus(p.flash_present, p.metered_speed);
            fire = 1'b1;
        end
        ctl.full_prev = full_on;
        r.menu_mode          = ctl.menu;
        r.manual_speed_index = ctl.manual_speed;
        r.timer_index        = ctl.timer_idx;
        r.focused            = ctl.focused;
        r.shutter_mode       = ctl.mode;
        r.shot_speed         = ctl.speed;
        r.expose             = fire;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            settings = CFG_RESET;
            ctl      = STATE_RESET;
            predicted_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                seen = i_result.data;
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no poll outstanding");
                    o_fail_count++;
                end else begin
                    want = predicted_q.pop_front();
                    check_field("menu_mode", 32'(want.menu_mode), 32'(seen.menu_mode));
                    check_field("manual_speed_index", 32'(want.manual_speed_index),
                                32'(seen.manual_speed_index));
                    check_field("timer_index", 32'(want.timer_index),
                                32'(seen.timer_index));
                    check_field("focused", 32'(want.focused), 32'(seen.focused));
                    check_field("shutter_mode", 32'(want.shutter_mode),
                                32'(seen.shutter_mode));
                    check_field("shot_speed", 32'(want.shot_speed), 32'(seen.shot_speed));
                    check_field("expose", 32'(want.expose), 32'(seen.expose));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_POLL_GATE:    settings.poll_gate_ms       = i_cfg.data;
                    CFG_LONG_PRESS:   settings.long_press_ms      = i_cfg.data;
                    CFG_RELEASE_HOLD: settings.release_hold_count = i_cfg.data[7:0];
                    CFG_SPEED_COUNT:  settings.speed_count        = i_cfg.data[5:0];
                    CFG_FLASH_CAP:    settings.flash_speed_cap    = i_cfg.data[4:0];
                    default: ;
                endcase
            end
            if (i_poll.valid && i_poll.ready)
                predicted_q.push_back(resolve_poll(i_poll.data));
        end
        o_pending = predicted_q.size();
    end

endmodule

### test/camera_button_mode_controller_tb.sv
// ----------------------------------------------------------------------------
// camera_button_mode_controller_tb
// Drives polls and register writes into the controller: a directed sequence
// through every menu, long and short pushes, speed and timer wrap, flash focus
// and expose, then random key and shutter activity over a series of register
// settings with random gaps on both channels. The checker beside the block
// predicts and compares; this module decides pass or fail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_button_mode_controller_tb;

    import cbmc_pkg::*;

    localparam int POLL_TOTAL      = 1800;
    localparam int PHASES          = 12;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int CYCLE_LIMIT     = 400000;

    logic i_clk;
    logic i_rst_n;

    cbmc_poll_if   poll_ch ();
    cbmc_result_if result_ch ();
    cbmc_cfg_if    cfg_ch ();

    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    int          src_gap_max;
    int          sink_gap_max;
    bit          hold_off_req;
    t_cfg        cfg_now;
    logic [31:0] now_ms;
    logic [2:0]  key_lv;
    logic        half_lv;
    logic        full_lv;
    logic        flash_lv;

    camera_button_mode_controller u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (poll_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    camera_button_mode_controller_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll       (poll_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[camera_button_mode_controller] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                gap = $urandom_range(0, sink_gap_max);
                if (gap != 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(result_ch.valid && result_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_poll(t_poll p);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.data  <= p;
        @(posedge i_clk);
        while (!(poll_ch.valid && poll_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic directed_poll(logic [31:0] t, logic [2:0] keys, logic hp, logic fp,
                                 logic fl, logic [4:0] met);
        t_poll p;
        p.time_ms        = t;
        p.key_down_level = keys[2];
        p.key_up_level   = keys[1];
        p.key_push_level = keys[0];
        p.half_press_pin = hp;
        p.full_press_pin = fp;
        p.flash_present  = fl;
        p.metered_speed  = met;
        now_ms = t;
        send_poll(p);
    endtask

    function automatic t_poll random_poll();
        int          r;
        int unsigned gate;
        int unsigned hold_long;
        logic [31:0] step;
        t_poll       p;
        gate      = cfg_now.poll_gate_ms;
        hold_long = cfg_now.long_press_ms;
        r = $urandom_range(0, 99);
        if (r < 25)
            step = $urandom_range(0, gate);
        else if (r < 75)
            step = gate + $urandom_range(0, 40);
        else if (r < 92)
            step = gate + $urandom_range(0, hold_long + 200);
        else if (r < 97)
            step = hold_long + $urandom_range(1, 500);
        else
            step = $urandom();
        now_ms = now_ms + step;
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 99) < 35)
                key_lv[i] = ~key_lv[i];
        if ($urandom_range(0, 99) < 25)
            half_lv = ~half_lv;
        if ($urandom_range(0, 99) < 20)
            full_lv = ~full_lv;
        if ($urandom_range(0, 99) < 8)
            flash_lv = ~flash_lv;
        p.time_ms        = now_ms;
        p.key_down_level = key_lv[2];
        p.key_up_level   = key_lv[1];
        p.key_push_level = key_lv[0];
        p.half_press_pin = half_lv;
        p.full_press_pin = full_lv;
        p.flash_present  = flash_lv;
        p.metered_speed  = $urandom_range(0, 31);
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // unused upper data bits carry noise
    task automatic apply_settings();
        logic [15:0] junk;
        junk = $urandom();
        write_reg(CFG_POLL_GATE, cfg_now.poll_gate_ms);
        write_reg(CFG_LONG_PRESS, cfg_now.long_press_ms);
        write_reg(CFG_RELEASE_HOLD, {junk[15:8], cfg_now.release_hold_count});
        write_reg(CFG_SPEED_COUNT, {junk[15:6], cfg_now.speed_count});
        write_reg(CFG_FLASH_CAP, {junk[15:5], cfg_now.flash_speed_cap});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle_polls();
        poll_ch.valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge i_clk);
    endtask

    initial begin
        int phase;
        int n;
        i_rst_n       = 1'b0;
        poll_ch.valid = 1'b0;
        poll_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_POLL_GATE;
        cfg_ch.data   = '0;
        src_gap_max   = 12;
        sink_gap_max  = 12;
        hold_off_req  = 1'b0;
        cfg_now       = CFG_RESET;
        now_ms        = '0;
        key_lv        = 3'b111;
        half_lv       = 1'b0;
        full_lv       = 1'b0;
        flash_lv      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // keys are {down, up, push}, active low
        directed_poll(32'd0,    3'b111, 1'b0, 1'b0, 1'b0, 5'd31);
        directed_poll(32'd100,  3'b110, 1'b0, 1'b0, 1'b0, 5'd0);
        directed_poll(32'd300,  3'b111, 1'b1, 1'b0, 1'b0, 5'd0);
        directed_poll(32'd450,  3'b110, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd600,  3'b111, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd750,  3'b110, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd900,  3'b111, 1'b1, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1050, 3'b011, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1200, 3'b111, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1350, 3'b101, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1500, 3'b111, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1650, 3'b101, 1'b0, 1'b0, 1'b0, 5'd7);
        directed_poll(32'd1800, 3'b111, 1'b0, 1'b1, 1'b1, 5'd5);
        directed_poll(32'd1950, 3'b111, 1'b0, 1'b1, 1'b1, 5'd5);
        directed_poll(32'd2100, 3'b110, 1'b0, 1'b0, 1'b1, 5'd5);
        directed_poll(32'd3600, 3'b111, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd3750, 3'b101, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd3900, 3'b111, 1'b1, 1'b1, 1'b0, 5'd5);
        directed_poll(32'd4050, 3'b101, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd4200, 3'b111, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd4350, 3'b101, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd4500, 3'b111, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd4650, 3'b101, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd4800, 3'b110, 1'b0, 1'b0, 1'b0, 5'd5);
        directed_poll(32'd6000, 3'b111, 1'b1, 1'b0, 1'b0, 5'd31);
        directed_poll(32'hFFFF_FFF0, 3'b110, 1'b0, 1'b0, 1'b0, 5'd0);
        directed_poll(32'hFFFF_FFFF, 3'b000, 1'b1, 1'b1, 1'b1, 5'd31);
        directed_poll(32'h0000_0100, 3'b111, 1'b0, 1'b0, 1'b0, 5'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            settle_polls();
            case (phase)
                0: cfg_now = CFG_RESET;
                1: cfg_now = '{16'd0, 16'd0, 8'd0, 6'd1, 5'd0};
                2: cfg_now = '{16'hFFFF, 16'hFFFF, 8'hFF, 6'd32, 5'd31};
                3: cfg_now = '{16'd50, 16'd400, 8'd1, 6'd0, 5'd31};
                4: cfg_now = '{16'd10, 16'd200, 8'd2, 6'h3F, 5'd5};
                default: begin
                    cfg_now.poll_gate_ms       = $urandom_range(0, 300);
                    cfg_now.long_press_ms      = $urandom_range(0, 2500);
                    cfg_now.release_hold_count = $urandom_range(0, 6);
                    cfg_now.speed_count        = $urandom_range(0, 63);
                    cfg_now.flash_speed_cap    = $urandom_range(0, 31);
                end
            endcase
            apply_settings();
            src_gap_max  = (phase % 3 == 1) ? 0 : 12;
            sink_gap_max = (phase % 4 == 2) ? 0 : 12;
            if (phase % 5 == 3) begin
                src_gap_max  = 0;
                hold_off_req = 1'b1;
            end
            if (phase % 2 == 1)
                now_ms = $urandom();
            for (n = 0; n < POLL_TOTAL / PHASES; n++)
                send_poll(random_poll());
        end
        settle_polls();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[camera_button_mode_controller] OK");
        else
            $display("[camera_button_mode_controller] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/cbmc_pkg.sv
src/cbmc_if.sv
src/cbmc_step.sv
src/cbmc_out_buf.sv
src/camera_button_mode_controller.sv
test/camera_button_mode_controller_checker.sv
test/camera_button_mode_controller_tb.sv
